// ----- rtl/tfpd_pkg.sv -----
// ----------------------------------------------------------------------------
// tfpd_pkg
// Shared widths, register indexes and the loop-gain reset value for the tape-follow PID.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package tfpd_pkg;

  localparam int unsigned SAMPLE_BITS_DEF = 12;
  localparam int unsigned GAIN_W          = 16;
  localparam int unsigned LIMIT_W         = 31;
  localparam int unsigned MID_W           = 15;
  localparam int unsigned DRIVE_W         = 16;
  localparam int unsigned ISUM_W          = 32;
  localparam int unsigned FRAC_SHIFT      = 16;
  localparam int unsigned CFG_IDX_W       = 3;
  localparam int unsigned CFG_DATA_W      = 31;

  localparam logic [CFG_IDX_W-1:0] REG_P_GAIN    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_I_GAIN    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_D_GAIN    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_LOOP_GAIN = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_INT_LIMIT = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_MID_SPEED = 3'd5;

  localparam logic signed [GAIN_W-1:0] LOOP_GAIN_RST = 16'sd256;

endpackage

// ----- rtl/tape_follow_pid_drive.sv -----
// ----------------------------------------------------------------------------
// tape_follow_pid_drive
// Each input transaction runs the P, I and D bit-serial products side by side,
// then a registered done handoff, the clamp state, the sum state, the loop-gain
// product, another registered done handoff and the output load. A new
// transaction is accepted only once the result is loaded; a stalled result delays that.
// Reset clears gains, limit, mid speed, integral and previous error, and sets
// loop gain to 256, which is 1/256 after the 16-bit fractional shift.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tape_follow_pid_drive #(
  parameter int unsigned SAMPLE_BITS = tfpd_pkg::SAMPLE_BITS_DEF
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  cfg_we_i,
  input  logic [tfpd_pkg::CFG_IDX_W-1:0]        cfg_idx_i,
  input  logic [tfpd_pkg::CFG_DATA_W-1:0]       cfg_wdata_i,
  input  logic                                  in_valid_i,
  output logic                                  in_ready_o,
  input  logic [SAMPLE_BITS-1:0]                left_sensor_i,
  input  logic [SAMPLE_BITS-1:0]                right_sensor_i,
  output logic                                  out_valid_o,
  input  logic                                  out_ready_i,
  output logic signed [tfpd_pkg::DRIVE_W-1:0]   left_drive_o,
  output logic signed [tfpd_pkg::DRIVE_W-1:0]   right_drive_o
);

  localparam int unsigned GW   = tfpd_pkg::GAIN_W;
  localparam int unsigned EW   = SAMPLE_BITS + 1;
  localparam int unsigned DW   = SAMPLE_BITS + 2;
  localparam int unsigned PW   = EW + GW;
  localparam int unsigned DPW  = DW + GW;
  localparam int unsigned IW   = tfpd_pkg::ISUM_W;
  localparam int unsigned ACW  = ((PW > IW) ? PW : IW) + 1;
  localparam int unsigned SW   = ((DPW > IW) ? DPW : IW) + 2;
  localparam int unsigned TW   = SW + GW;
  localparam int unsigned OW   = tfpd_pkg::DRIVE_W;
  localparam int unsigned FR   = tfpd_pkg::FRAC_SHIFT;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_MUL   = 3'd1;
  localparam logic [2:0] S_CLAMP = 3'd2;
  localparam logic [2:0] S_SUM   = 3'd3;
  localparam logic [2:0] S_LOOP  = 3'd4;
  localparam logic [2:0] S_OUT   = 3'd5;

  logic [2:0] state_q;

  logic signed [GW-1:0]                   p_gain_q, i_gain_q, d_gain_q, loop_gain_q;
  logic [tfpd_pkg::LIMIT_W-1:0]           limit_q;
  logic [tfpd_pkg::MID_W-1:0]             mid_q;

  logic signed [EW-1:0]  prev_q;
  logic signed [EW-1:0]  err_d;
  logic signed [DW-1:0]  derr_d;
  logic signed [IW-1:0]  isum_q;

  logic                  in_acc;
  logic                  pid_done, loop_done;
  logic                  loop_start;
  logic signed [PW-1:0]  pprod, iprod;
  logic signed [DPW-1:0] dprod;
  logic signed [TW-1:0]  tprod;

  logic signed [ACW-1:0] acc, lim_pos, lim_neg, acc_cl;
  logic signed [SW-1:0]  sum_d;
  logic signed [SW-1:0]  corr;
  logic signed [SW:0]    left_w, right_w, mid_w;
  logic                  out_load;
  logic                  out_valid_q;
  logic signed [OW-1:0]  left_q, right_q;

  function automatic logic signed [OW-1:0] sat_drive(input logic signed [SW:0] v);
    logic top_ones;
    logic top_zeros;
    top_ones  = &v[SW:OW-1];
    top_zeros = ~|v[SW:OW-1];
    if (top_ones || top_zeros) begin
      sat_drive = v[OW-1:0];
    end else if (v[SW]) begin
      sat_drive = {1'b1, {(OW-1){1'b0}}};
    end else begin
      sat_drive = {1'b0, {(OW-1){1'b1}}};
    end
  endfunction

  assign in_ready_o = (state_q == S_IDLE);
  assign in_acc     = in_valid_i && in_ready_o;

  assign err_d  = $signed({1'b0, left_sensor_i}) - $signed({1'b0, right_sensor_i});
  assign derr_d = DW'(err_d) - DW'(prev_q);

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p_gain_q    <= '0;
      i_gain_q    <= '0;
      d_gain_q    <= '0;
      loop_gain_q <= tfpd_pkg::LOOP_GAIN_RST;
      limit_q     <= '0;
      mid_q       <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        tfpd_pkg::REG_P_GAIN:    p_gain_q    <= cfg_wdata_i[GW-1:0];
        tfpd_pkg::REG_I_GAIN:    i_gain_q    <= cfg_wdata_i[GW-1:0];
        tfpd_pkg::REG_D_GAIN:    d_gain_q    <= cfg_wdata_i[GW-1:0];
        tfpd_pkg::REG_LOOP_GAIN: loop_gain_q <= cfg_wdata_i[GW-1:0];
        tfpd_pkg::REG_INT_LIMIT: limit_q     <= cfg_wdata_i[tfpd_pkg::LIMIT_W-1:0];
        tfpd_pkg::REG_MID_SPEED: mid_q       <= cfg_wdata_i[tfpd_pkg::MID_W-1:0];
        default: ;
      endcase
    end
  end

  tfpd_sermul #(.AW(EW), .BW(GW)) u_pmul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (in_acc),
    .a_i     (err_d),
    .b_i     (p_gain_q),
    .done_o  (pid_done),
    .prod_o  (pprod)
  );

  tfpd_sermul #(.AW(EW), .BW(GW)) u_imul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (in_acc),
    .a_i     (err_d),
    .b_i     (i_gain_q),
    .done_o  (),
    .prod_o  (iprod)
  );

  tfpd_sermul #(.AW(DW), .BW(GW)) u_dmul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (in_acc),
    .a_i     (derr_d),
    .b_i     (d_gain_q),
    .done_o  (),
    .prod_o  (dprod)
  );

  // add the new integral increment first, then clamp to the limit
  assign lim_pos = ACW'(signed'({1'b0, limit_q}));
  assign lim_neg = -lim_pos;
  assign acc     = ACW'(isum_q) + ACW'(iprod);

  always_comb begin
    if (acc > lim_pos) begin
      acc_cl = lim_pos;
    end else if (acc < lim_neg) begin
      acc_cl = lim_neg;
    end else begin
      acc_cl = acc;
    end
  end

  assign sum_d      = SW'(pprod) + SW'(isum_q) + SW'(dprod);
  assign loop_start = (state_q == S_SUM);

  tfpd_sermul #(.AW(SW), .BW(GW)) u_lmul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (loop_start),
    .a_i     (sum_d),
    .b_i     (loop_gain_q),
    .done_o  (loop_done),
    .prod_o  (tprod)
  );

  // arithmetic shift floors toward minus infinity
  assign corr    = tprod[TW-1:FR];
  assign mid_w   = (SW+1)'(signed'({1'b0, mid_q}));
  assign left_w  = mid_w - (SW+1)'(corr);
  assign right_w = mid_w + (SW+1)'(corr);

  assign out_load = (state_q == S_OUT) && (!out_valid_q || out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      prev_q  <= '0;
      isum_q  <= '0;
    end else begin
      case (state_q)
        S_IDLE: begin
          if (in_acc) begin
            prev_q  <= err_d;
            state_q <= S_MUL;
          end
        end
        S_MUL: begin
          if (pid_done) begin
            state_q <= S_CLAMP;
          end
        end
        S_CLAMP: begin
          isum_q  <= acc_cl[IW-1:0];
          state_q <= S_SUM;
        end
        S_SUM: begin
          state_q <= S_LOOP;
        end
        S_LOOP: begin
          if (loop_done) begin
            state_q <= S_OUT;
          end
        end
        S_OUT: begin
          if (out_load) begin
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // output register: hold the result until the transaction completes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      left_q  <= sat_drive(left_w);
      right_q <= sat_drive(right_w);
    end
  end

  assign out_valid_o   = out_valid_q;
  assign left_drive_o  = left_q;
  assign right_drive_o = right_q;

endmodule

// ----- rtl/tfpd_sermul.sv -----
// ----------------------------------------------------------------------------
// tfpd_sermul
// Bit-serial signed multiplier: one multiplier bit per cycle, LSB first.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tfpd_sermul #(
  parameter int unsigned AW = 13,
  parameter int unsigned BW = tfpd_pkg::GAIN_W
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  logic signed [AW-1:0]  a_i,
  input  logic signed [BW-1:0]  b_i,
  output logic                  done_o,
  output logic signed [AW+BW-1:0] prod_o
);

  localparam int unsigned CW = (BW > 1) ? $clog2(BW) : 1;

  logic signed [AW-1:0] a_q;
  logic signed [AW:0]   hi_q, hi_d;
  logic [BW-1:0]        lo_q, lo_d;
  logic [CW-1:0]        cnt_q;
  logic                 busy_q;
  logic                 done_q;
  logic                 last;
  logic signed [AW+1:0] a_ext;
  logic signed [AW+1:0] addend;
  logic signed [AW+1:0] sum;

  assign last  = (cnt_q == CW'(BW - 1));
  assign a_ext = (AW+2)'(a_q);

  always_comb begin
    // top bit of a two's complement multiplier carries negative weight
    if (!lo_q[0]) begin
      addend = '0;
    end else if (last) begin
      addend = -a_ext;
    end else begin
      addend = a_ext;
    end
    sum  = (AW+2)'(hi_q) + addend;
    hi_d = sum[AW+1:1];
    lo_d = {sum[0], lo_q[BW-1:1]};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= busy_q && last;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (last) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      a_q  <= a_i;
      hi_q <= '0;
      lo_q <= b_i;
    end else if (busy_q) begin
      hi_q <= hi_d;
      lo_q <= lo_d;
    end
  end

  assign done_o = done_q;
  assign prod_o = {hi_q[AW-1:0], lo_q};

endmodule
